// ----- rtl/fpre_pkg.sv -----
// Package for the fractional-N PLL register encoder.
// Holds field widths, chip register addresses and data, the encoded-value and
// write structs, and the function that picks the write for each slot of a run.
`default_nettype none

package fpre_pkg;

  localparam int unsigned XTAL_HZ_DEF = 27000000;

  localparam int unsigned FREQ_W      = 30;
  localparam int unsigned DIV_W       = 12;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam int unsigned FRAC_DENOM = 1000000;
  localparam int unsigned FRAC_W     = 20;
  localparam int unsigned Q_W        = 7;
  localparam int unsigned P1_W       = 18;
  localparam int unsigned P2_W       = 20;
  localparam int unsigned MS_W       = 18;

  localparam logic [FREQ_W-1:0] PLL_MIN = 30'd600000000;
  localparam logic [FREQ_W-1:0] PLL_MAX = 30'd1000000000;
  localparam logic [DIV_W-1:0]  DIV_MIN = 12'd4;
  localparam logic [DIV_W-1:0]  DIV_MAX = 12'd2048;

  // 128 * 4, common offset of p1 and ms_p1
  localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;
  localparam logic [P2_W-1:0] P3        = P2_W'(FRAC_DENOM);

  localparam int unsigned NUM_WRITES = 22;
  localparam int unsigned SLOT_W     = 5;

  localparam logic [SLOT_W-1:0] SLOT_OFF   = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_PLL   = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_MS    = 5'd9;
  localparam logic [SLOT_W-1:0] SLOT_CLK1  = 5'd17;
  localparam logic [SLOT_W-1:0] SLOT_CLK0  = 5'd18;
  localparam logic [SLOT_W-1:0] SLOT_CLK2  = 5'd19;
  localparam logic [SLOT_W-1:0] SLOT_RST   = 5'd20;
  localparam logic [SLOT_W-1:0] SLOT_EN    = 5'd21;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_EN;

  localparam logic [7:0] ADDR_OUT_EN   = 8'd3;
  localparam logic [7:0] ADDR_CLK0     = 8'd16;
  localparam logic [7:0] ADDR_CLK1     = 8'd17;
  localparam logic [7:0] ADDR_CLK2     = 8'd18;
  localparam logic [7:0] ADDR_PLL_BASE = 8'd26;
  localparam logic [7:0] ADDR_MS_BASE  = 8'd50;
  localparam logic [7:0] ADDR_PLL_RST  = 8'd177;

  localparam logic [7:0] DATA_ALL_OFF = 8'hFF;
  localparam logic [7:0] DATA_CLK1    = 8'h4F;
  localparam logic [7:0] DATA_CLK0    = 8'h80;
  localparam logic [7:0] DATA_CLK2    = 8'h80;
  localparam logic [7:0] DATA_PLL_RST = 8'hA0;
  localparam logic [7:0] DATA_OUT1_ON = 8'hFD;

  typedef struct packed {
    logic [P1_W-1:0] p1;
    logic [P2_W-1:0] p2;
    logic [MS_W-1:0] ms;
  } enc_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       pause;
    logic       last;
  } wr_t;

  function automatic wr_t write_for_slot(input logic [SLOT_W-1:0] slot, input enc_t enc);
    wr_t             w;
    logic [2:0]      k;
    logic [7:0][7:0] pll_b;
    logic [7:0][7:0] ms_b;
    w     = '0;
    k     = '0;
    pll_b = {enc.p2[7:0], enc.p2[15:8], {P3[19:16], enc.p2[19:16]},
             enc.p1[7:0], enc.p1[15:8], {6'd0, enc.p1[17:16]}, P3[7:0], P3[15:8]};
    ms_b  = {8'd0, 8'd0, 8'd0, enc.ms[7:0], enc.ms[15:8], {6'd0, enc.ms[17:16]},
             8'd1, 8'd0};
    if (slot == SLOT_OFF) begin
      w.addr = ADDR_OUT_EN;
      w.data = DATA_ALL_OFF;
    end else if (slot < SLOT_MS) begin
      k      = 3'(slot - SLOT_PLL);
      w.addr = ADDR_PLL_BASE + 8'(k);
      w.data = pll_b[k];
    end else if (slot < SLOT_CLK1) begin
      k      = 3'(slot - SLOT_MS);
      w.addr = ADDR_MS_BASE + 8'(k);
      w.data = ms_b[k];
    end else if (slot == SLOT_CLK1) begin
      w.addr = ADDR_CLK1;
      w.data = DATA_CLK1;
    end else if (slot == SLOT_CLK0) begin
      w.addr = ADDR_CLK0;
      w.data = DATA_CLK0;
    end else if (slot == SLOT_CLK2) begin
      w.addr = ADDR_CLK2;
      w.data = DATA_CLK2;
    end else if (slot == SLOT_RST) begin
      w.addr = ADDR_PLL_RST;
      w.data = DATA_PLL_RST;
    end else begin
      w.addr  = ADDR_OUT_EN;
      w.data  = DATA_OUT1_ON;
      w.pause = 1'b1;
      w.last  = 1'b1;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fpre_seq.sv -----
// Write sequencer: holds one set of encoded values and plays out the run of
// register writes, one item per cycle while the output is not stalled, through a registered output stage.
// Depends on fpre_pkg.
`default_nettype none

module fpre_seq (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               enc_valid_i,
  output logic                                    enc_ready_o,
  input  wire fpre_pkg::enc_t                     enc_i,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [fpre_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // reg_addr, reg_data
  output logic                                    m_axis_tuser,  // pause_before
  output logic                                    m_axis_tlast   // last
);

  logic                          busy_q;
  logic [fpre_pkg::SLOT_W-1:0]   slot_q;
  fpre_pkg::enc_t                enc_q;
  logic                          out_vld_q;
  fpre_pkg::wr_t                 out_q;

  logic out_free;
  logic issue;
  logic last_issue;
  logic load;

  assign out_free    = !out_vld_q || m_axis_tready;
  assign issue       = busy_q && out_free;
  assign last_issue  = issue && (slot_q == fpre_pkg::LAST_SLOT);
  assign enc_ready_o = !busy_q || last_issue;
  assign load        = enc_valid_i && enc_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      slot_q    <= fpre_pkg::SLOT_OFF;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        slot_q <= fpre_pkg::SLOT_OFF;
      end else begin
        if (issue) begin
          slot_q <= slot_q + fpre_pkg::SLOT_W'(1);
        end
        if (last_issue) begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= fpre_pkg::write_for_slot(slot_q, enc_q);
    end
    if (load) begin
      enc_q <= enc_i;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.data, out_q.addr};
  assign m_axis_tuser  = out_q.pause;
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// ----- rtl/fractional_pll_register_encoder.sv -----
// Top level of the fractional-N PLL register encoder: input clamp, divide and
// encode pipeline, and the write sequencer. Depends on fpre_pkg and fpre_seq.
//
// Each accepted item (PLL frequency, output divider) yields a run of 22 register
// writes on the master side, one per cycle while m_axis_tready is high; the last
// one carries tlast and tuser (pause before write). The next item is taken while
// the current run plays out. With the sequencer idle, the first write passes
// from acceptance through a 12-stage pipeline (clamp, three constant-reciprocal
// divisions each with a multiply, back-multiply and one correction), the
// sequencer's hold register, then the output stage.
`default_nettype none

module fractional_pll_register_encoder #(
  parameter int unsigned XTAL_HZ = fpre_pkg::XTAL_HZ_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [fpre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // pll_frequency, output_divider
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [fpre_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // reg_addr, reg_data
  output logic                                    m_axis_tuser,  // pause_before
  output logic                                    m_axis_tlast   // last
);

  localparam int unsigned FW   = fpre_pkg::FREQ_W;
  localparam int unsigned CW   = fpre_pkg::FRAC_W;
  localparam int unsigned XW   = $clog2(XTAL_HZ + 1);
  localparam int unsigned AW   = $clog2(fpre_pkg::PLL_MAX / XTAL_HZ + 1);
  localparam logic [63:0] M1   = (64'd1 << FW) / XTAL_HZ;
  localparam int unsigned M1W  = $clog2(M1 + 1);
  localparam int unsigned PW1  = FW + M1W;
  localparam int unsigned NW   = XW + CW;
  localparam int unsigned LW   = (NW + 1) / 2;
  localparam int unsigned HW   = NW - LW;
  localparam logic [63:0] M2   = (64'd1 << NW) / XTAL_HZ;
  localparam int unsigned M2W  = $clog2(M2 + 1);
  localparam int unsigned PW2  = NW + M2W;
  localparam int unsigned TW   = CW + fpre_pkg::Q_W;
  localparam logic [63:0] M3   = (64'd1 << TW) / fpre_pkg::FRAC_DENOM;
  localparam int unsigned M3W  = $clog2(M3 + 1);
  localparam int unsigned PW3  = TW + M3W;
  localparam int unsigned NSTG = 12;

  logic [NSTG:1] v_q;
  logic          adv;
  logic          in_acc;
  logic          enc_ready;

  logic [FW-1:0]                  f_in, f_cl;
  logic [fpre_pkg::DIV_W-1:0]     d_in, d_cl;

  logic [FW-1:0]                  f_q [1:3];
  logic [fpre_pkg::DIV_W-1:0]     d1_q;
  logic [fpre_pkg::MS_W-1:0]      ms_q [2:11];
  logic [AW-1:0]                  aq2_q, aq3_q;
  logic [FW-1:0]                  ap3_q;
  logic [AW-1:0]                  a_q [4:11];
  logic [XW-1:0]                  rest4_q;
  logic [NW-1:0]                  n_q [5:8];
  logic [HW+M2W-1:0]              ph6_q;
  logic [LW+M2W-1:0]              pl6_q;
  logic [CW-1:0]                  bq7_q, bq8_q;
  logic [NW-1:0]                  bp8_q;
  logic [CW-1:0]                  b_q [9:11];
  logic [fpre_pkg::Q_W-1:0]       q10_q, q11_q;
  logic [TW-1:0]                  qp11_q;
  fpre_pkg::enc_t                 enc_q;

  logic [PW1-1:0]                 prod1;
  logic [FW-1:0]                  diff4;
  logic [XW:0]                    rem4;
  logic [PW2-1:0]                 sum7;
  logic [NW-1:0]                  rem9;
  logic [PW3-1:0]                 prod10;
  logic [TW-1:0]                  rem12;
  logic [fpre_pkg::Q_W-1:0]       q12;
  logic [fpre_pkg::P2_W-1:0]      p2_12;

  assign adv           = !v_q[NSTG] || enc_ready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-1:1], in_acc};
    end
  end

  always_comb begin
    f_in = s_axis_tdata[FW-1:0];
    d_in = s_axis_tdata[FW +: fpre_pkg::DIV_W];
    f_cl = (f_in < fpre_pkg::PLL_MIN) ? fpre_pkg::PLL_MIN :
           (f_in > fpre_pkg::PLL_MAX) ? fpre_pkg::PLL_MAX : f_in;
    d_cl = (d_in < fpre_pkg::DIV_MIN) ? fpre_pkg::DIV_MIN :
           (d_in > fpre_pkg::DIV_MAX) ? fpre_pkg::DIV_MAX : d_in;

    prod1  = PW1'(f_q[1]) * PW1'(M1);
    diff4  = f_q[3] - ap3_q;
    rem4   = (XW + 1)'(diff4);
    sum7   = (PW2'(ph6_q) << LW) + PW2'(pl6_q);
    rem9   = n_q[8] - bp8_q;
    prod10 = PW3'({b_q[9], {fpre_pkg::Q_W{1'b0}}}) * PW3'(M3);
    rem12  = {b_q[11], {fpre_pkg::Q_W{1'b0}}} - qp11_q;
    if (rem12 >= TW'(fpre_pkg::FRAC_DENOM)) begin
      q12   = q11_q + fpre_pkg::Q_W'(1);
      p2_12 = fpre_pkg::P2_W'(rem12 - TW'(fpre_pkg::FRAC_DENOM));
    end else begin
      q12   = q11_q;
      p2_12 = fpre_pkg::P2_W'(rem12);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q[1] <= f_cl;
      d1_q   <= d_cl;
      f_q[2] <= f_q[1];
      f_q[3] <= f_q[2];
      ms_q[2] <= fpre_pkg::MS_W'({d1_q, {fpre_pkg::Q_W{1'b0}}}) - fpre_pkg::P1_OFFSET;
      for (int i = 3; i <= 11; i++) begin
        ms_q[i] <= ms_q[i-1];
      end

      aq2_q <= prod1[FW +: AW];
      aq3_q <= aq2_q;
      ap3_q <= FW'(aq2_q) * FW'(XTAL_HZ);

      if (rem4 >= (XW + 1)'(XTAL_HZ)) begin
        a_q[4]  <= aq3_q + AW'(1);
        rest4_q <= XW'(rem4 - (XW + 1)'(XTAL_HZ));
      end else begin
        a_q[4]  <= aq3_q;
        rest4_q <= XW'(rem4);
      end
      for (int i = 5; i <= 11; i++) begin
        a_q[i] <= a_q[i-1];
      end

      n_q[5] <= NW'(rest4_q) * NW'(fpre_pkg::FRAC_DENOM);
      for (int i = 6; i <= 8; i++) begin
        n_q[i] <= n_q[i-1];
      end

      ph6_q <= (HW + M2W)'(n_q[5][NW-1:LW]) * (HW + M2W)'(M2);
      pl6_q <= (LW + M2W)'(n_q[5][LW-1:0]) * (LW + M2W)'(M2);

      bq7_q <= sum7[NW +: CW];
      bq8_q <= bq7_q;
      bp8_q <= NW'(bq7_q) * NW'(XTAL_HZ);

      b_q[9]  <= (rem9 >= NW'(XTAL_HZ)) ? bq8_q + CW'(1) : bq8_q;
      b_q[10] <= b_q[9];
      b_q[11] <= b_q[10];

      q10_q  <= prod10[TW +: fpre_pkg::Q_W];
      q11_q  <= q10_q;
      qp11_q <= TW'(q10_q) * TW'(fpre_pkg::FRAC_DENOM);

      enc_q.p1 <= fpre_pkg::P1_W'({a_q[11], q12}) - fpre_pkg::P1_OFFSET;
      enc_q.p2 <= p2_12;
      enc_q.ms <= ms_q[11];
    end
  end

  fpre_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enc_valid_i   (v_q[NSTG]),
    .enc_ready_o   (enc_ready),
    .enc_i         (enc_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/fpre_checker.sv -----
// Port-level checks for the fractional-N PLL register encoder, bound to the
// top level. Depends on fpre_pkg.
`default_nettype none

module fpre_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic [fpre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [fpre_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                               m_axis_tuser,
  input wire logic                               m_axis_tlast
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_pause_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("pause flag not tied to final write");

  a_last_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata == {fpre_pkg::DATA_OUT1_ON, fpre_pkg::ADDR_OUT_EN})
    else $error("final write is not the output enable");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid && m_axis_tready && m_axis_tlast) |->
      m_axis_tdata == {fpre_pkg::DATA_ALL_OFF, fpre_pkg::ADDR_OUT_EN})
    else $error("run does not start with outputs off");

endmodule

bind fractional_pll_register_encoder fpre_checker u_fpre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- bench/tb_fractional_pll_register_encoder.sv -----
// Self-checking bench for fractional_pll_register_encoder, depends on fpre_pkg and the RTL.
// Directed request table, then random requests, each checked write by write against
// a local predictor of the 22-write register run, with random idling on both sides.
`default_nettype none

module tb_fractional_pll_register_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 396;
  localparam int unsigned CALM_TAIL       = 40;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  typedef struct {
    logic [fpre_pkg::FREQ_W-1:0] freq;
    logic [fpre_pkg::DIV_W-1:0]  div;
    bit                          typed;
    logic [fpre_pkg::P1_W-1:0]   p1;
    logic [fpre_pkg::P2_W-1:0]   p2;
    logic [fpre_pkg::MS_W-1:0]   ms;
  } request_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [fpre_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // pll_frequency, output_divider
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [fpre_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // reg_addr, reg_data
  logic                             m_axis_tuser;   // pause_before
  logic                             m_axis_tlast;   // last

  fpre_pkg::wr_t pending_writes[$];
  fpre_pkg::wr_t want_wr;
  int unsigned   mismatch_count;
  int unsigned   stall_left;
  bit            calm;

  request_t request_table[] = '{
    '{30'd0,          12'd0,    1'b1, 18'd2332, 20'd444416, 18'd0},
    '{30'd600000000,  12'd4,    1'b1, 18'd2332, 20'd444416, 18'd0},
    '{30'd1000000000, 12'd2048, 1'b1, 18'd4228, 20'd740736, 18'd261632},
    '{30'h3FFFFFFF,   12'hFFF,  1'b1, 18'd4228, 20'd740736, 18'd261632},
    '{30'd599999999,  12'd3,    1'b1, 18'd2332, 20'd444416, 18'd0},
    '{30'd1000000001, 12'd2049, 1'b1, 18'd4228, 20'd740736, 18'd261632},
    '{30'd621000000,  12'd5,    1'b1, 18'd2432, 20'd0,      18'd128},
    '{30'd999999999,  12'd2047, 1'b0, '0, '0, '0},
    '{30'h2AAAAAAA,   12'h555,  1'b0, '0, '0, '0},
    '{30'h15555555,   12'hAAA,  1'b0, '0, '0, '0},
    '{30'h20000000,   12'h800,  1'b0, '0, '0, '0},
    '{30'd810000000,  12'd30,   1'b0, '0, '0, '0},
    '{30'd648000001,  12'd1,    1'b0, '0, '0, '0},
    '{30'd700000000,  12'd7,    1'b0, '0, '0, '0}
  };

  fractional_pll_register_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic fpre_pkg::enc_t encode_request(
      input logic [fpre_pkg::FREQ_W-1:0] freq_in,
      input logic [fpre_pkg::DIV_W-1:0]  div_in);
    longint unsigned freq, div, xtal, denom, whole, rest, frac, carry;
    fpre_pkg::enc_t  enc;
    freq  = 64'(freq_in);
    div   = 64'(div_in);
    xtal  = 64'(fpre_pkg::XTAL_HZ_DEF);
    denom = 64'(fpre_pkg::FRAC_DENOM);
    if (freq < 64'(fpre_pkg::PLL_MIN)) freq = 64'(fpre_pkg::PLL_MIN);
    if (freq > 64'(fpre_pkg::PLL_MAX)) freq = 64'(fpre_pkg::PLL_MAX);
    if (div < 64'(fpre_pkg::DIV_MIN)) div = 64'(fpre_pkg::DIV_MIN);
    if (div > 64'(fpre_pkg::DIV_MAX)) div = 64'(fpre_pkg::DIV_MAX);
    whole  = freq / xtal;
    rest   = freq % xtal;
    frac   = (rest * denom) / xtal;
    carry  = (128 * frac) / denom;
    enc.p1 = fpre_pkg::P1_W'(128 * whole + carry - 512);
    enc.p2 = fpre_pkg::P2_W'(128 * frac - denom * carry);
    enc.ms = fpre_pkg::MS_W'(128 * div - 512);
    return enc;
  endfunction

  task automatic queue_register_run(input fpre_pkg::enc_t enc);
    logic [19:0]     denom;
    logic [7:0][7:0] pll_bytes;
    logic [7:0][7:0] ms_bytes;
    denom = 20'(fpre_pkg::FRAC_DENOM);
    pll_bytes[0] = denom[15:8];
    pll_bytes[1] = denom[7:0];
    pll_bytes[2] = {6'd0, enc.p1[17:16]};
    pll_bytes[3] = enc.p1[15:8];
    pll_bytes[4] = enc.p1[7:0];
    pll_bytes[5] = {denom[19:16], enc.p2[19:16]};
    pll_bytes[6] = enc.p2[15:8];
    pll_bytes[7] = enc.p2[7:0];
    ms_bytes     = '0;
    ms_bytes[1]  = 8'd1;
    ms_bytes[2]  = {6'd0, enc.ms[17:16]};
    ms_bytes[3]  = enc.ms[15:8];
    ms_bytes[4]  = enc.ms[7:0];
    pending_writes.push_back('{fpre_pkg::ADDR_OUT_EN, fpre_pkg::DATA_ALL_OFF, 1'b0, 1'b0});
    for (int i = 0; i < 8; i++)
      pending_writes.push_back('{fpre_pkg::ADDR_PLL_BASE + 8'(i), pll_bytes[i], 1'b0, 1'b0});
    for (int i = 0; i < 8; i++)
      pending_writes.push_back('{fpre_pkg::ADDR_MS_BASE + 8'(i), ms_bytes[i], 1'b0, 1'b0});
    pending_writes.push_back('{fpre_pkg::ADDR_CLK1, fpre_pkg::DATA_CLK1, 1'b0, 1'b0});
    pending_writes.push_back('{fpre_pkg::ADDR_CLK0, fpre_pkg::DATA_CLK0, 1'b0, 1'b0});
    pending_writes.push_back('{fpre_pkg::ADDR_CLK2, fpre_pkg::DATA_CLK2, 1'b0, 1'b0});
    pending_writes.push_back('{fpre_pkg::ADDR_PLL_RST, fpre_pkg::DATA_PLL_RST, 1'b0, 1'b0});
    pending_writes.push_back('{fpre_pkg::ADDR_OUT_EN, fpre_pkg::DATA_OUT1_ON, 1'b1, 1'b1});
  endtask

  task automatic send_request(input request_t req, input bit allow_gap);
    fpre_pkg::enc_t enc;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, req.div, req.freq};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req.typed) begin
      enc.p1 = req.p1;
      enc.p2 = req.p2;
      enc.ms = req.ms;
    end else begin
      enc = encode_request(req.freq, req.div);
    end
    queue_register_run(enc);
  endtask

  // sink side: check each accepted write, then pick tready for the next cycle
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write addr %0d data %h pause %b last %b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want_wr = pending_writes.pop_front();
        if (m_axis_tdata[7:0] !== want_wr.addr) begin
          $display("%0t: reg_addr expected %0d actual %0d", $time, want_wr.addr,
                   m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want_wr.data) begin
          $display("%0t: reg_data (addr %0d) expected %h actual %h", $time, want_wr.addr,
                   want_wr.data, m_axis_tdata[15:8]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want_wr.pause) begin
          $display("%0t: pause_before (addr %0d) expected %b actual %b", $time,
                   want_wr.addr, want_wr.pause, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tlast !== want_wr.last) begin
          $display("%0t: last (addr %0d) expected %b actual %b", $time, want_wr.addr,
                   want_wr.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      stall_left    <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    request_t req;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    stall_left     = 0;
    calm           = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (request_table[i]) send_request(request_table[i], 1'b0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      req.typed = 1'b0;
      req.p1    = '0;
      req.p2    = '0;
      req.ms    = '0;
      if ($urandom_range(0, 3) != 0)
        req.freq = fpre_pkg::FREQ_W'($urandom_range(fpre_pkg::PLL_MIN, fpre_pkg::PLL_MAX));
      else req.freq = fpre_pkg::FREQ_W'($urandom);
      if ($urandom_range(0, 3) != 0)
        req.div = fpre_pkg::DIV_W'($urandom_range(fpre_pkg::DIV_MIN, fpre_pkg::DIV_MAX));
      else req.div = fpre_pkg::DIV_W'($urandom);
      send_request(req, !calm);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- fractional_pll_register_encoder.f -----
rtl/fpre_pkg.sv
rtl/fpre_seq.sv
rtl/fractional_pll_register_encoder.sv
rtl/fpre_checker.sv
bench/tb_fractional_pll_register_encoder.sv
